FILE: sv/svssm_pkg.sv
// Shared types, constants and helper functions for the stepped value display driver.
package svssm_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_UP   = 2'd1,
    FUNC_DOWN = 2'd2,
    FUNC_LOAD = 2'd3
  } func_t;

  localparam logic [1:0] CFG_IDX_MUX_PERIOD = 2'd0;
  localparam logic [1:0] CFG_IDX_VALUE_MAX  = 2'd1;
  localparam logic [1:0] CFG_IDX_VALUE_MIN  = 2'd2;

  localparam logic [6:0] MUX_PERIOD_RST = 7'd1;
  localparam logic [7:0] VALUE_MAX_RST  = 8'd40;
  localparam logic [7:0] VALUE_MIN_RST  = 8'd1;

  localparam logic [1:0] DIGIT_OFF   = 2'b00;
  localparam logic [1:0] DIGIT_TENS  = 2'b01;
  localparam logic [1:0] DIGIT_UNITS = 2'b10;

  typedef struct packed {
    func_t      func;
    logic [7:0] load_value;
    logic       hold;
  } item_t;

  typedef struct packed {
    logic       display_valid;
    logic [6:0] segments;
    logic [1:0] digit_enable;
    logic       decimal_point;
    logic       value_changed;
    logic [7:0] new_value;
  } result_t;

  // Segment patterns a..g in bits 0..6 for the decimal digits.
  function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

  // Quotient by ten for an 8-bit value, by reciprocal multiply (exact for every 8-bit input).
  function automatic logic [4:0] div10(input logic [7:0] v);
    logic [15:0] prod;
    prod = {8'd0, v} * 16'd205;
    return prod[15:11];
  endfunction

endpackage

FILE: sv/svssm_in_stage.sv
// Input register stage that holds one accepted transaction for the core.
module svssm_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  svssm_pkg::item_t  in_item,
  output logic              s1_valid,
  output svssm_pkg::item_t  s1_item,
  input  logic              s1_fire
);

  logic             valid_r;
  logic             valid_nxt;
  svssm_pkg::item_t item_r;

  assign in_ready = !valid_r || s1_fire;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

FILE: sv/svssm_core.sv
// Value and tick state, configuration registers and the result logic.
module svssm_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  svssm_pkg::item_t   s1_item,
  input  logic               s1_valid,
  input  logic               s1_fire,
  output logic               has_result,
  output svssm_pkg::result_t result
);

  logic [6:0] mux_period_r;
  logic [7:0] value_max_r;
  logic [7:0] value_min_r;
  logic [7:0] current_value_r;
  logic [7:0] current_value_nxt;
  logic [7:0] tick_count_r;
  logic [7:0] tick_count_nxt;

  logic [7:0] stepped;
  logic [7:0] clamped;
  logic [7:0] twice;
  logic [8:0] tick_inc;
  logic [4:0] quot;
  logic [7:0] rem;
  logic [4:0] tens_wide;
  logic [3:0] tens;
  logic [3:0] units;
  logic       tens_hit;
  logic       units_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mux_period_r <= svssm_pkg::MUX_PERIOD_RST;
      value_max_r  <= svssm_pkg::VALUE_MAX_RST;
      value_min_r  <= svssm_pkg::VALUE_MIN_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        svssm_pkg::CFG_IDX_MUX_PERIOD: mux_period_r <= cfg_data[6:0];
        svssm_pkg::CFG_IDX_VALUE_MAX:  value_max_r  <= cfg_data;
        svssm_pkg::CFG_IDX_VALUE_MIN:  value_min_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    quot      = svssm_pkg::div10(current_value_r);
    rem       = current_value_r - ({3'd0, quot} * 8'd10);
    units     = rem[3:0];
    if (quot >= 5'd20) begin
      tens_wide = quot - 5'd20;
    end else if (quot >= 5'd10) begin
      tens_wide = quot - 5'd10;
    end else begin
      tens_wide = quot;
    end
    tens = tens_wide[3:0];

    twice     = {mux_period_r, 1'b0};
    tens_hit  = (tick_count_r == {1'b0, mux_period_r});
    units_hit = (tick_count_r == twice);
    tick_inc  = {1'b0, tick_count_r} + 9'd1;

    if (s1_item.func == svssm_pkg::FUNC_UP) begin
      stepped = current_value_r + 8'd1;
    end else begin
      stepped = current_value_r - 8'd1;
    end
    clamped = (stepped > value_max_r) ? value_max_r : stepped;
    clamped = (clamped < value_min_r) ? value_min_r : clamped;

    result            = '0;
    has_result        = 1'b0;
    current_value_nxt = current_value_r;
    tick_count_nxt    = tick_count_r;

    case (s1_item.func)
      svssm_pkg::FUNC_UP, svssm_pkg::FUNC_DOWN: begin
        current_value_nxt    = clamped;
        has_result           = 1'b1;
        result.value_changed = 1'b1;
        result.new_value     = clamped;
      end
      svssm_pkg::FUNC_LOAD: begin
        current_value_nxt = s1_item.load_value;
      end
      default: begin
        if (units_hit) begin
          has_result           = 1'b1;
          result.display_valid = 1'b1;
          result.segments      = svssm_pkg::seg_pattern(units);
          result.digit_enable  = svssm_pkg::DIGIT_UNITS;
          result.decimal_point = s1_item.hold;
        end else if (tens_hit) begin
          has_result           = 1'b1;
          result.display_valid = 1'b1;
          result.segments      = svssm_pkg::seg_pattern(tens);
          result.digit_enable  = (tens != 4'd0) ? svssm_pkg::DIGIT_TENS
                                                : svssm_pkg::DIGIT_OFF;
        end
        tick_count_nxt = (tick_inc > {1'b0, twice}) ? 8'd0 : tick_inc[7:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_value_r <= 8'd0;
      tick_count_r    <= 8'd0;
    end else if (s1_fire) begin
      current_value_r <= current_value_nxt;
      tick_count_r    <= tick_count_nxt;
    end
  end

  a_step_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_item.func == svssm_pkg::FUNC_UP || s1_item.func == svssm_pkg::FUNC_DOWN)
     && value_min_r <= value_max_r)
    |=> (current_value_r >= $past(value_min_r) && current_value_r <= $past(value_max_r)))
    else $error("stepped value outside clamp limits");

  a_load_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_item.func == svssm_pkg::FUNC_LOAD)
    |=> (current_value_r == $past(s1_item.load_value)))
    else $error("load transaction did not store its value");

  a_result_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && has_result) |-> (result.display_valid != result.value_changed))
    else $error("result is neither or both of display and step");

  a_point_units: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && result.decimal_point) |-> (result.digit_enable == svssm_pkg::DIGIT_UNITS))
    else $error("decimal point lit outside the units phase");

endmodule

FILE: sv/svssm_out_stage.sv
// Output register that holds one result transaction until the receiver takes it.
module svssm_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_load,
  input  svssm_pkg::result_t res_in,
  output logic               can_take,
  output logic               out_valid,
  input  logic               out_ready,
  output svssm_pkg::result_t out_res
);

  logic               valid_r;
  logic               valid_nxt;
  svssm_pkg::result_t res_r;

  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

FILE: sv/stepped_value_seven_segment_mux_top.sv
// Top level of the stepped value two-digit multiplexed seven-segment driver.
// The input stream carries one command per transaction: in_tuser holds the
// function (tick, step up, step down, load) and in_tdata the load value and
// the hold flag. A step transaction yields one result reporting the clamped
// value; a tick transaction yields a display result only when the tick count
// reaches the tens or the units phase; a load yields nothing.
// Results leave on the out stream; out_tuser tells display results from
// step results. The cfg channel writes mux_period, value_max and value_min
// and is always ready; write it only while no transaction is in flight.
// A transaction accepted into the input register is processed by the
// compute stage, and its result is registered and shows on out_tvalid.
// Unless the receiver stalls, the block takes one transaction every cycle,
// set by the input register, the compute stage and the output register.
// Reset clears the value and the tick count and restores the register
// defaults. When the receiver stalls, the result waits in the output
// register; the next transaction is still taken when it makes no result,
// and one more is buffered in the input register otherwise.
module stepped_value_seven_segment_mux_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // load_value[7:0], hold[8], zero fill
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // segments[6:0], digit_enable[8:7],
                                  // decimal_point[9], new_value[17:10], zero fill
  output logic [1:0]  out_tuser,  // display_valid[0], value_changed[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  svssm_pkg::item_t   in_item;
  svssm_pkg::item_t   s1_item;
  svssm_pkg::result_t core_res;
  svssm_pkg::result_t out_res;
  logic               s1_valid;
  logic               s1_fire;
  logic               has_result;
  logic               can_take;

  assign in_item.func       = svssm_pkg::func_t'(in_tuser);
  assign in_item.load_value = in_tdata[7:0];
  assign in_item.hold       = in_tdata[8];

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid && (!has_result || can_take);

  svssm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_fire  (s1_fire)
  );

  svssm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s1_item    (s1_item),
    .s1_valid   (s1_valid),
    .s1_fire    (s1_fire),
    .has_result (has_result),
    .result     (core_res)
  );

  svssm_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (s1_fire && has_result),
    .res_in    (core_res),
    .can_take  (can_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {6'd0, out_res.new_value, out_res.decimal_point,
                      out_res.digit_enable, out_res.segments};
  assign out_tuser = {out_res.value_changed, out_res.display_valid};

endmodule

FILE: test/stepped_value_seven_segment_mux_checker.sv
// Checker for the stepped value display driver: predicts every result and compares it.
module stepped_value_seven_segment_mux_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // load_value[7:0], hold[8], zero fill
  input  logic [1:0]  in_tuser,   // func[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // segments[6:0], digit_enable[8:7],
                                  // decimal_point[9], new_value[17:10], zero fill
  input  logic [1:0]  out_tuser,  // display_valid[0], value_changed[1]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          pending,
  output int          fail_count
);

  logic [6:0]          period_reg;
  logic [7:0]          max_reg;
  logic [7:0]          min_reg;
  logic [7:0]          value_reg;
  logic [7:0]          phase_count;
  svssm_pkg::result_t  expected_drive_q[$];
  int                  n_errors = 0;

  assign fail_count = n_errors;

  function automatic logic [6:0] digit_segments(input logic [7:0] digit);
    case (digit)
      8'd0:    return 7'h3F;
      8'd1:    return 7'h06;
      8'd2:    return 7'h5B;
      8'd3:    return 7'h4F;
      8'd4:    return 7'h66;
      8'd5:    return 7'h6D;
      8'd6:    return 7'h7D;
      8'd7:    return 7'h07;
      8'd8:    return 7'h7F;
      8'd9:    return 7'h6F;
      default: return 7'h00;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    n_errors++;
  endtask

  task automatic predict_command(input svssm_pkg::func_t op, input logic [7:0] ld,
                                 input logic dp_req);
    svssm_pkg::result_t res;
    logic [7:0] v;
    logic [8:0] twice;
    logic [8:0] nxt;
    logic [7:0] tens;
    logic [7:0] units;
    res = '0;
    case (op)
      svssm_pkg::FUNC_UP, svssm_pkg::FUNC_DOWN: begin
        v = (op == svssm_pkg::FUNC_UP) ? value_reg + 8'd1 : value_reg - 8'd1;
        if (v > max_reg) v = max_reg;
        if (v < min_reg) v = min_reg;
        value_reg = v;
        res.value_changed = 1'b1;
        res.new_value = v;
        expected_drive_q.push_back(res);
      end
      svssm_pkg::FUNC_LOAD: begin
        value_reg = ld;
      end
      default: begin
        twice = {1'b0, period_reg, 1'b0};
        tens = (value_reg / 8'd10) % 8'd10;
        units = value_reg % 8'd10;
        if ({1'b0, phase_count} == {2'b00, period_reg}) begin
          res.display_valid = 1'b1;
          res.segments = digit_segments(tens);
          res.digit_enable = (tens != 8'd0) ? svssm_pkg::DIGIT_TENS : svssm_pkg::DIGIT_OFF;
        end
        // The units phase takes precedence when both compares match.
        if ({1'b0, phase_count} == twice) begin
          res = '0;
          res.display_valid = 1'b1;
          res.segments = digit_segments(units);
          res.digit_enable = svssm_pkg::DIGIT_UNITS;
          res.decimal_point = dp_req;
        end
        if (res.display_valid) expected_drive_q.push_back(res);
        nxt = {1'b0, phase_count} + 9'd1;
        if (nxt > twice) nxt = '0;
        phase_count = nxt[7:0];
      end
    endcase
  endtask

  task automatic check_transaction();
    svssm_pkg::result_t want;
    if (expected_drive_q.size() == 0) begin
      report_mismatch("result with none expected", {12'd0, out_tuser, out_tdata[17:0]}, '0);
    end else begin
      want = expected_drive_q.pop_front();
      if (out_tuser[0] !== want.display_valid)
        report_mismatch("display_valid", 32'(out_tuser[0]), 32'(want.display_valid));
      if (out_tdata[6:0] !== want.segments)
        report_mismatch("segments", 32'(out_tdata[6:0]), 32'(want.segments));
      if (out_tdata[8:7] !== want.digit_enable)
        report_mismatch("digit_enable", 32'(out_tdata[8:7]), 32'(want.digit_enable));
      if (out_tdata[9] !== want.decimal_point)
        report_mismatch("decimal_point", 32'(out_tdata[9]), 32'(want.decimal_point));
      if (out_tuser[1] !== want.value_changed)
        report_mismatch("value_changed", 32'(out_tuser[1]), 32'(want.value_changed));
      if (out_tdata[17:10] !== want.new_value)
        report_mismatch("new_value", 32'(out_tdata[17:10]), 32'(want.new_value));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      period_reg = svssm_pkg::MUX_PERIOD_RST;
      max_reg = svssm_pkg::VALUE_MAX_RST;
      min_reg = svssm_pkg::VALUE_MIN_RST;
      value_reg = '0;
      phase_count = '0;
      expected_drive_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          svssm_pkg::CFG_IDX_MUX_PERIOD: period_reg = cfg_data[6:0];
          svssm_pkg::CFG_IDX_VALUE_MAX:  max_reg = cfg_data;
          svssm_pkg::CFG_IDX_VALUE_MIN:  min_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_transaction();
      if (in_tvalid && in_tready)
        predict_command(svssm_pkg::func_t'(in_tuser), in_tdata[7:0], in_tdata[8]);
      pending <= expected_drive_q.size();
    end
  end

endmodule

FILE: test/stepped_value_seven_segment_mux_top_tb.sv
// Testbench top for the stepped value display driver: stimulus, flow control and verdict.
module stepped_value_seven_segment_mux_top_tb;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 150;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          results_outstanding;
  int          fail_count;
  int          squeeze_req = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;

  stepped_value_seven_segment_mux_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  stepped_value_seven_segment_mux_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (results_outstanding),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_cmd(input svssm_pkg::func_t op, input logic [7:0] ld,
                          input logic dp_req);
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {7'd0, dp_req, ld};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic random_command(input int tick_pct);
    svssm_pkg::func_t op;
    logic [7:0]       ld;
    if ($urandom_range(0, 99) < tick_pct) begin
      op = svssm_pkg::FUNC_TICK;
    end else begin
      case ($urandom_range(0, 4))
        0, 1:    op = svssm_pkg::FUNC_UP;
        2, 3:    op = svssm_pkg::FUNC_DOWN;
        default: op = svssm_pkg::FUNC_LOAD;
      endcase
    end
    case ($urandom_range(0, 7))
      0:       ld = 8'h00;
      1:       ld = 8'hFF;
      default: ld = 8'($urandom_range(0, 255));
    endcase
    send_cmd(op, ld, $urandom_range(0, 1) != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Waits for the block to drain, then reprograms it and runs random traffic.
  task automatic run_phase(input logic [6:0] per, input logic [7:0] hi, input logic [7:0] lo,
                           input int n_items, input int tick_pct, input bit gaps,
                           input bit squeeze);
    do @(posedge clk); while (results_outstanding != 0);
    repeat (8) @(posedge clk);
    write_reg(svssm_pkg::CFG_IDX_MUX_PERIOD, {1'b0, per});
    write_reg(svssm_pkg::CFG_IDX_VALUE_MAX, hi);
    write_reg(svssm_pkg::CFG_IDX_VALUE_MIN, lo);
    cfg_valid <= 1'b0;
    gaps_on = gaps;
    burst_left = 0;
    if (squeeze) squeeze_req <= squeeze_req + 1;
    repeat (n_items) random_command(tick_pct);
    in_tvalid <= 1'b0;
  endtask

  initial begin : stimulus
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= svssm_pkg::FUNC_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= svssm_pkg::CFG_IDX_MUX_PERIOD;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Default registers: period 1, clamp range 1 to 40.
    send_cmd(svssm_pkg::FUNC_TICK, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_TICK, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_TICK, 8'h00, 1'b1);
    send_cmd(svssm_pkg::FUNC_DOWN, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_UP, 8'hFF, 1'b1);
    send_cmd(svssm_pkg::FUNC_LOAD, 8'hFF, 1'b1);
    send_cmd(svssm_pkg::FUNC_TICK, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_TICK, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_TICK, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_UP, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_LOAD, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_DOWN, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_LOAD, 8'd99, 1'b0);
    send_cmd(svssm_pkg::FUNC_TICK, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_TICK, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_TICK, 8'h00, 1'b1);
    send_cmd(svssm_pkg::FUNC_LOAD, 8'd100, 1'b1);
    send_cmd(svssm_pkg::FUNC_TICK, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_TICK, 8'h00, 1'b0);
    send_cmd(svssm_pkg::FUNC_TICK, 8'h00, 1'b1);
    send_cmd(svssm_pkg::FUNC_LOAD, 8'h55, 1'b0);
    send_cmd(svssm_pkg::FUNC_LOAD, 8'hAA, 1'b1);
    send_cmd(svssm_pkg::FUNC_DOWN, 8'h00, 1'b0);
    in_tvalid <= 1'b0;

    run_phase(7'd0,   8'd255, 8'd0,   80,  50, 1'b1, 1'b0);
    run_phase(7'd127, 8'd200, 8'd10,  270, 97, 1'b0, 1'b0);
    run_phase(7'd3,   8'd20,  8'd50,  60,  50, 1'b1, 1'b0);
    run_phase(7'd1,   8'd0,   8'd0,   160, 40, 1'b0, 1'b1);
    run_phase(7'd2,   8'd255, 8'd255, 50,  50, 1'b1, 1'b0);
    for (int i = 0; i < 3; i++) begin
      run_phase(($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, 6)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 60)),
                60, 50, $urandom_range(0, 1) != 0, 1'b0);
    end

    do @(posedge clk); while (results_outstanding != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int seen_squeeze;
    int ready_len;
    int stall_len;
    seen_squeeze = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_req != seen_squeeze) begin
        seen_squeeze = squeeze_req;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          ready_len = $urandom_range(20, 60);
          stall_len = 0;
        end else begin
          ready_len = $urandom_range(1, 10);
          stall_len = $urandom_range(1, 6);
        end
        out_tready <= 1'b1;
        repeat (ready_len) @(posedge clk);
        if (stall_len != 0) begin
          out_tready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
